/* hw/rtl/als_pkg.sv */
// ----------------------------------------------------------------------------
// Ambient light lux unit - shared definitions
// Field widths, code names, range tables, divide-by-625 reciprocals and the
// elaboration-time helper that turns the correction coefficients into fixed point.
// ----------------------------------------------------------------------------
package als_pkg;

    localparam int RAW_W     = 16;
    localparam int CODE_W    = 4;
    localparam int GAIN_W    = 2;
    localparam int LUX_W     = 35;
    localparam int MODE_W    = 4;
    localparam int SHIFT_W   = 4;

    localparam int LUX_FRAC_BITS      = 8;
    localparam int COEF_FRAC_BITS_DEF = 48;

    // Linear lux x in unsigned Q16
    localparam int XQ_W    = 33;
    localparam int XQ_FRAC = 16;

    // x * 2^k = floor(raw * 9 * 2^23 / 625), split into quotient and remainder parts
    localparam int SCALED_W   = 20;
    localparam int QUOT_W     = 10;
    localparam int RMD_W      = 10;
    localparam int FRAC_W     = 23;
    localparam int DIV_N      = 625;
    localparam int DIV_M1_W   = 21;
    localparam int DIV_M1_SH  = 30;
    localparam int PROD1_W    = SCALED_W + DIV_M1_W;
    localparam int DIV_M2_W   = 34;
    localparam int DIV_M2_SH  = 20;
    localparam int PROD2_W    = RMD_W + DIV_M2_W;

    localparam logic [DIV_M1_W-1:0] DIV_M1 =
        DIV_M1_W'(((64'd1 << DIV_M1_SH) + 64'(DIV_N) - 64'd1) / 64'(DIV_N));
    // remainder scaling by 2^23 folded into the reciprocal
    localparam logic [DIV_M2_W-1:0] DIV_M2 =
        DIV_M2_W'(((64'd1 << (DIV_M2_SH + FRAC_W)) + 64'(DIV_N) - 64'd1) / 64'(DIV_N));

    // Integration time codes
    localparam logic [CODE_W-1:0] TIME_100MS = 4'd0;
    localparam logic [CODE_W-1:0] TIME_200MS = 4'd1;
    localparam logic [CODE_W-1:0] TIME_400MS = 4'd2;
    localparam logic [CODE_W-1:0] TIME_800MS = 4'd3;
    localparam logic [CODE_W-1:0] TIME_50MS  = 4'd8;
    localparam logic [CODE_W-1:0] TIME_25MS  = 4'd12;

    // Gain codes
    localparam logic [GAIN_W-1:0] GAIN_X1   = 2'd0;
    localparam logic [GAIN_W-1:0] GAIN_X2   = 2'd1;
    localparam logic [GAIN_W-1:0] GAIN_X1_8 = 2'd2;
    localparam logic [GAIN_W-1:0] GAIN_X1_4 = 2'd3;

    localparam int NUM_LIMITS = 8;
    localparam int NUM_MODES  = 9;
    localparam logic [MODE_W-1:0] MODE_COARSE = 4'd8;

    localparam logic [15:0] MODE_LIMIT [NUM_LIMITS] = '{
        16'd230, 16'd460, 16'd1840, 16'd3680, 16'd7360, 16'd14720, 16'd29440, 16'd58880
    };
    localparam logic [CODE_W-1:0] MODE_TIME [NUM_MODES] = '{
        TIME_800MS, TIME_800MS, TIME_800MS, TIME_800MS, TIME_400MS,
        TIME_200MS, TIME_100MS, TIME_50MS, TIME_25MS
    };
    localparam logic [GAIN_W-1:0] MODE_GAIN [NUM_MODES] = '{
        GAIN_X2, GAIN_X1, GAIN_X1_4, GAIN_X1_8, GAIN_X1_8,
        GAIN_X1_8, GAIN_X1_8, GAIN_X1_8, GAIN_X1_8
    };

    typedef struct packed {
        logic [CODE_W-1:0] ic;
        logic [GAIN_W-1:0] gc;
        logic              bad;
        logic              full;
    } t_side;

    typedef struct packed {
        logic       bad;
        logic [2:0] shift;
    } t_time;

    function automatic t_time time_info(input logic [CODE_W-1:0] code);
        t_time res;
        res = '{bad: 1'b0, shift: 3'd0};
        unique case (code)
            TIME_25MS:  res.shift = 3'd0;
            TIME_50MS:  res.shift = 3'd1;
            TIME_100MS: res.shift = 3'd2;
            TIME_200MS: res.shift = 3'd3;
            TIME_400MS: res.shift = 3'd4;
            TIME_800MS: res.shift = 3'd5;
            default:    res.bad   = 1'b1;
        endcase
        return res;
    endfunction

    function automatic logic [2:0] gain_shift(input logic [GAIN_W-1:0] code);
        logic [2:0] res;
        unique case (code)
            GAIN_X1:   res = 3'd3;
            GAIN_X2:   res = 3'd4;
            GAIN_X1_8: res = 3'd0;
            GAIN_X1_4: res = 3'd1;
            default:   res = 3'd0;
        endcase
        return res;
    endfunction

    // round(num * 2^f / den) by restoring long division, elaboration only
    function automatic longint unsigned fixed_const(input longint unsigned num,
                                                    input longint unsigned den,
                                                    input int f);
        longint unsigned q;
        longint unsigned r;
        logic b;
        q = 64'd0;
        r = 64'd0;
        for (int i = 0; i < 64 + f; i++) begin
            b = 1'b0;
            if (i < 64) begin
                b = num[63 - i];
            end
            r = {r[62:0], b};
            q = {q[62:0], 1'b0};
            if (r >= den) begin
                r = r - den;
                q = q + 64'd1;
            end
        end
        if ((r << 1) >= den) begin
            q = q + 64'd1;
        end
        return q;
    endfunction

endpackage

/* hw/rtl/als_linear.sv */
// ----------------------------------------------------------------------------
// Linear lux front end
// Three stages: raw*9 times a reciprocal of 625, remainder, remainder times a
// second reciprocal, then the range shift. Gives x = raw*1.8432/2^k in Q16.
// ----------------------------------------------------------------------------
module als_linear (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [als_pkg::RAW_W-1:0]   i_raw,
    input  logic [als_pkg::CODE_W-1:0]  i_ic,
    input  logic [als_pkg::GAIN_W-1:0]  i_gc,
    output logic                        o_valid,
    output als_pkg::t_side              o_side,
    output logic [als_pkg::XQ_W-1:0]    o_xq
);

    als_pkg::t_time                        n_time;
    als_pkg::t_side                        n_side;
    logic [als_pkg::SCALED_W-1:0]          n_scaled;
    logic [als_pkg::PROD1_W-1:0]           n_prod1;
    logic [als_pkg::SHIFT_W-1:0]           n_shift;
    logic [als_pkg::SCALED_W-1:0]          n_diff;
    logic [als_pkg::PROD2_W-1:0]           n_prod2;
    logic [als_pkg::XQ_W-1:0]              n_xq;

    logic                                  r1_valid;
    als_pkg::t_side                        r1_side;
    logic [als_pkg::SCALED_W-1:0]          r1_scaled;
    logic [als_pkg::QUOT_W-1:0]            r1_quot;
    logic [als_pkg::SHIFT_W-1:0]           r1_shift;

    logic                                  r2_valid;
    als_pkg::t_side                        r2_side;
    logic [als_pkg::RMD_W-1:0]             r2_rmd;
    logic [als_pkg::QUOT_W-1:0]            r2_quot;
    logic [als_pkg::SHIFT_W-1:0]           r2_shift;

    logic                                  r3_valid;
    als_pkg::t_side                        r3_side;
    logic [als_pkg::XQ_W-1:0]              r3_xq;

    // stage 1: quotient of raw*9 by 625
    always_comb begin
        n_time      = als_pkg::time_info(i_ic);
        n_side.ic   = i_ic;
        n_side.gc   = i_gc;
        n_side.bad  = n_time.bad;
        n_side.full = (i_raw == '1);
        n_scaled    = (als_pkg::SCALED_W'(i_raw) << 3) + als_pkg::SCALED_W'(i_raw);
        n_prod1     = als_pkg::PROD1_W'(n_scaled) * als_pkg::PROD1_W'(als_pkg::DIV_M1);
        n_shift     = als_pkg::SHIFT_W'(n_time.shift)
                    + als_pkg::SHIFT_W'(als_pkg::gain_shift(i_gc));
    end

    // stage 2: remainder
    assign n_diff = r1_scaled
                  - als_pkg::SCALED_W'(als_pkg::SCALED_W'(r1_quot)
                                       * als_pkg::SCALED_W'(als_pkg::DIV_N));

    // stage 3: fraction bits of the remainder, then the range shift
    always_comb begin
        n_prod2 = als_pkg::PROD2_W'(r2_rmd) * als_pkg::PROD2_W'(als_pkg::DIV_M2);
        n_xq    = {r2_quot, n_prod2[als_pkg::DIV_M2_SH +: als_pkg::FRAC_W]} >> r2_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_side   <= n_side;
        r1_scaled <= n_scaled;
        r1_quot   <= n_prod1[als_pkg::DIV_M1_SH +: als_pkg::QUOT_W];
        r1_shift  <= n_shift;

        r2_side   <= r1_side;
        r2_rmd    <= n_diff[als_pkg::RMD_W-1:0];
        r2_quot   <= r1_quot;
        r2_shift  <= r1_shift;

        r3_side   <= r2_side;
        r3_xq     <= n_xq;
    end

    assign o_valid = r3_valid;
    assign o_side  = r3_side;
    assign o_xq    = r3_xq;

endmodule

/* hw/rtl/als_horner_step.sv */
// ----------------------------------------------------------------------------
// One Horner step of the lux correction polynomial
// res = KADD + trunc(a * x / 2^SH), truncated toward zero. Four stages:
// magnitude, partial products, sum and shift, sign and add. The last step
// drops KADD, clamps negatives to zero and saturates at the output maximum.
// ----------------------------------------------------------------------------
module als_horner_step #(
    parameter int     AW   = 32,
    parameter int     OW   = 32,
    parameter int     SH   = 16,
    parameter longint KADD = 0,
    parameter bit     LAST = 1'b0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  als_pkg::t_side               i_side,
    input  logic signed [AW-1:0]         i_a,
    input  logic [als_pkg::XQ_W-1:0]     i_xq,
    output logic                         o_valid,
    output als_pkg::t_side               o_side,
    output logic [als_pkg::XQ_W-1:0]     o_xq,
    output logic signed [OW-1:0]         o_res
);

    localparam int CW   = 32;
    localparam int NCH  = (AW + CW - 1) / CW;
    localparam int MW   = NCH * CW;
    localparam int PPW  = CW + als_pkg::XQ_W;
    localparam int PW   = MW + als_pkg::XQ_W;
    localparam int RW   = PW - SH;
    localparam int CMPW = (RW > OW) ? RW : OW;

    localparam logic [OW-1:0] OMAX = {1'b0, {(OW-1){1'b1}}};

    logic [AW-1:0]                n_abs;
    logic [PPW-1:0]               n_pp [NCH];
    logic [PW-1:0]                n_prod;
    logic [RW-1:0]                n_shm;
    logic signed [OW-1:0]         n_res;

    logic                         r0_valid;
    als_pkg::t_side               r0_side;
    logic [als_pkg::XQ_W-1:0]     r0_xq;
    logic                         r0_neg;
    logic [MW-1:0]                r0_mag;

    logic                         r1_valid;
    als_pkg::t_side               r1_side;
    logic [als_pkg::XQ_W-1:0]     r1_xq;
    logic                         r1_neg;
    logic [PPW-1:0]               r1_pp [NCH];

    logic                         r2_valid;
    als_pkg::t_side               r2_side;
    logic [als_pkg::XQ_W-1:0]     r2_xq;
    logic                         r2_neg;
    logic [RW-1:0]                r2_shm;

    logic                         r3_valid;
    als_pkg::t_side               r3_side;
    logic [als_pkg::XQ_W-1:0]     r3_xq;
    logic signed [OW-1:0]         r3_res;

    assign n_abs = i_a[AW-1] ? AW'(-i_a) : AW'(i_a);

    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            n_pp[i] = PPW'(r0_mag[i*CW +: CW]) * PPW'(r0_xq);
        end
    end

    always_comb begin
        n_prod = '0;
        for (int i = 0; i < NCH; i++) begin
            n_prod = n_prod + (PW'(r1_pp[i]) << (i * CW));
        end
        n_shm = RW'(n_prod >> SH);
    end

    if (LAST) begin : g_last
        // drop negative values, saturate large ones
        always_comb begin
            if (r2_neg) begin
                n_res = '0;
            end else if (CMPW'(r2_shm) > CMPW'(OMAX)) begin
                n_res = OMAX;
            end else begin
                n_res = OW'(r2_shm);
            end
        end
    end else begin : g_acc
        localparam logic signed [OW-1:0] KOW = OW'(KADD);
        always_comb begin
            if (r2_neg) begin
                n_res = KOW - OW'(r2_shm);
            end else begin
                n_res = KOW + OW'(r2_shm);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r0_valid <= i_valid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_side <= i_side;
        r0_xq   <= i_xq;
        r0_neg  <= i_a[AW-1];
        r0_mag  <= MW'(n_abs);

        r1_side <= r0_side;
        r1_xq   <= r0_xq;
        r1_neg  <= r0_neg;
        r1_pp   <= n_pp;

        r2_side <= r1_side;
        r2_xq   <= r1_xq;
        r2_neg  <= r1_neg;
        r2_shm  <= n_shm;

        r3_side <= r2_side;
        r3_xq   <= r2_xq;
        r3_res  <= n_res;
    end

    assign o_valid = r3_valid;
    assign o_side  = r3_side;
    assign o_xq    = r3_xq;
    assign o_res   = r3_res;

endmodule

/* hw/rtl/als_mode_sel.sv */
// ----------------------------------------------------------------------------
// Range selection and result register
// Compares corrected lux against the mode limits, picks the best mode, looks
// up its time and gain codes and registers the finished result word.
// ----------------------------------------------------------------------------
module als_mode_sel (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  als_pkg::t_side               i_side,
    input  logic [als_pkg::LUX_W-1:0]    i_y,
    output logic                         o_strobe,
    output logic [als_pkg::LUX_W-1:0]    o_lux_q8,
    output logic [als_pkg::MODE_W-1:0]   o_best_mode,
    output logic [als_pkg::CODE_W-1:0]   o_next_integration_code,
    output logic [als_pkg::GAIN_W-1:0]   o_next_gain_code,
    output logic                         o_settled,
    output logic                         o_saturated,
    output logic                         o_bad_setting
);

    logic [als_pkg::NUM_LIMITS-1:0]  n_over;
    logic [als_pkg::MODE_W-1:0]      n_mode;
    logic [als_pkg::CODE_W-1:0]      n_time;
    logic [als_pkg::GAIN_W-1:0]      n_gain;
    logic                            n_settled;
    logic [als_pkg::LUX_W-1:0]       n_lux;

    logic                            r_strobe;
    logic [als_pkg::LUX_W-1:0]       r_lux;
    logic [als_pkg::MODE_W-1:0]      r_mode;
    logic [als_pkg::CODE_W-1:0]      r_time;
    logic [als_pkg::GAIN_W-1:0]      r_gain;
    logic                            r_settled;
    logic                            r_saturated;
    logic                            r_bad;

    always_comb begin
        for (int i = 0; i < als_pkg::NUM_LIMITS; i++) begin
            n_over[i] = i_y > (als_pkg::LUX_W'(als_pkg::MODE_LIMIT[i])
                               << als_pkg::LUX_FRAC_BITS);
        end
        // first limit not exceeded; full scale or a bad code forces the coarsest mode
        n_mode = als_pkg::MODE_COARSE;
        if (!i_side.full && !i_side.bad) begin
            for (int i = als_pkg::NUM_LIMITS - 1; i >= 0; i--) begin
                if (!n_over[i]) begin
                    n_mode = als_pkg::MODE_W'(i);
                end
            end
        end
        n_time    = als_pkg::MODE_TIME[n_mode];
        n_gain    = als_pkg::MODE_GAIN[n_mode];
        n_settled = !i_side.bad && (n_time == i_side.ic) && (n_gain == i_side.gc);
        n_lux     = i_side.bad ? '0 : i_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lux       <= n_lux;
        r_mode      <= n_mode;
        r_time      <= n_time;
        r_gain      <= n_gain;
        r_settled   <= n_settled;
        r_saturated <= i_side.full;
        r_bad       <= i_side.bad;
    end

    assign o_strobe                = r_strobe;
    assign o_lux_q8                = r_lux;
    assign o_best_mode             = r_mode;
    assign o_next_integration_code = r_time;
    assign o_next_gain_code        = r_gain;
    assign o_settled               = r_settled;
    assign o_saturated             = r_saturated;
    assign o_bad_setting           = r_bad;

endmodule

/* hw/rtl/als_lux_autorange_unit.sv */
// ----------------------------------------------------------------------------
// Ambient light lux unit with polynomial correction and range selection
//
// Usage: drive i_raw_count, i_integration_code and i_gain_code and raise
// start; the word is taken at a rising edge where start is high and busy is
// low. busy is high only while reset is applied and in the first cycle after,
// so a new word may be taken on every clock.
// Each word gives one result: o_strobe is high for exactly one cycle with all
// result fields valid in that cycle. The word passes the input register, the
// linear scaling, 4 Horner steps and the range selection register in turn.
// Throughput is one word per cycle; the depth is set by the four chained
// wide multiplies of the Horner evaluation.
// The receiver cannot hold results off; every result is shown once and must
// be captured in its strobe cycle. Reset clears all valid bits, so no
// result appears for words in flight at reset.
// ----------------------------------------------------------------------------
module als_lux_autorange_unit #(
    parameter int COEF_FRAC_BITS = als_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [als_pkg::RAW_W-1:0]    i_raw_count,
    input  logic [als_pkg::CODE_W-1:0]   i_integration_code,
    input  logic [als_pkg::GAIN_W-1:0]   i_gain_code,
    output logic                         o_strobe,
    output logic [als_pkg::LUX_W-1:0]    o_lux_q8,
    output logic [als_pkg::MODE_W-1:0]   o_best_mode,
    output logic [als_pkg::CODE_W-1:0]   o_next_integration_code,
    output logic [als_pkg::GAIN_W-1:0]   o_next_gain_code,
    output logic                         o_settled,
    output logic                         o_saturated,
    output logic                         o_bad_setting
);

    localparam int F = COEF_FRAC_BITS;

    localparam int W3 = 32;
    localparam int W2 = F - 20;
    localparam int W1 = F - 4;
    localparam int W0 = F + 6;
    localparam int WY = als_pkg::LUX_W + 1;

    localparam longint K3 = longint'(als_pkg::fixed_const(64'd60135,
                                         64'd100000000000000000, F));
    localparam longint K2 = -longint'(als_pkg::fixed_const(64'd93924,
                                         64'd10000000000000, F));
    localparam longint K1 = longint'(als_pkg::fixed_const(64'd81488,
                                         64'd1000000000, F));
    localparam longint K0 = longint'(als_pkg::fixed_const(64'd10023,
                                         64'd10000, F - 8));

    localparam int SH_Y = F - 8 + als_pkg::XQ_FRAC - als_pkg::LUX_FRAC_BITS;

    localparam logic signed [W3-1:0] K3_IN = W3'(K3);

    logic                          accept;
    logic                          r_busy;
    logic                          r_in_valid;
    logic [als_pkg::RAW_W-1:0]     r_raw;
    logic [als_pkg::CODE_W-1:0]    r_ic;
    logic [als_pkg::GAIN_W-1:0]    r_gc;

    logic                          lin_valid;
    als_pkg::t_side                lin_side;
    logic [als_pkg::XQ_W-1:0]      lin_xq;

    logic                          s2_valid;
    als_pkg::t_side                s2_side;
    logic [als_pkg::XQ_W-1:0]      s2_xq;
    logic signed [W2-1:0]          s2_t;

    logic                          s1_valid;
    als_pkg::t_side                s1_side;
    logic [als_pkg::XQ_W-1:0]      s1_xq;
    logic signed [W1-1:0]          s1_t;

    logic                          s0_valid;
    als_pkg::t_side                s0_side;
    logic [als_pkg::XQ_W-1:0]      s0_xq;
    logic signed [W0-1:0]          s0_t;

    logic                          y_valid;
    als_pkg::t_side                y_side;
    logic signed [WY-1:0]          y_res;

    assign accept = start && !busy;
    assign busy   = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_in_valid <= 1'b0;
        end else begin
            r_busy     <= 1'b0;
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_raw <= i_raw_count;
            r_ic  <= i_integration_code;
            r_gc  <= i_gain_code;
        end
    end

    als_linear u_linear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_raw   (r_raw),
        .i_ic    (r_ic),
        .i_gc    (r_gc),
        .o_valid (lin_valid),
        .o_side  (lin_side),
        .o_xq    (lin_xq)
    );

    als_horner_step #(
        .AW   (W3),
        .OW   (W2),
        .SH   (als_pkg::XQ_FRAC),
        .KADD (K2),
        .LAST (1'b0)
    ) u_step3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lin_valid),
        .i_side  (lin_side),
        .i_a     (K3_IN),
        .i_xq    (lin_xq),
        .o_valid (s2_valid),
        .o_side  (s2_side),
        .o_xq    (s2_xq),
        .o_res   (s2_t)
    );

    als_horner_step #(
        .AW   (W2),
        .OW   (W1),
        .SH   (als_pkg::XQ_FRAC),
        .KADD (K1),
        .LAST (1'b0)
    ) u_step2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .i_side  (s2_side),
        .i_a     (s2_t),
        .i_xq    (s2_xq),
        .o_valid (s1_valid),
        .o_side  (s1_side),
        .o_xq    (s1_xq),
        .o_res   (s1_t)
    );

    als_horner_step #(
        .AW   (W1),
        .OW   (W0),
        .SH   (als_pkg::XQ_FRAC + 8),
        .KADD (K0),
        .LAST (1'b0)
    ) u_step1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_side  (s1_side),
        .i_a     (s1_t),
        .i_xq    (s1_xq),
        .o_valid (s0_valid),
        .o_side  (s0_side),
        .o_xq    (s0_xq),
        .o_res   (s0_t)
    );

    als_horner_step #(
        .AW   (W0),
        .OW   (WY),
        .SH   (SH_Y),
        .KADD (64'sd0),
        .LAST (1'b1)
    ) u_step0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s0_valid),
        .i_side  (s0_side),
        .i_a     (s0_t),
        .i_xq    (s0_xq),
        .o_valid (y_valid),
        .o_side  (y_side),
        .o_xq    (),
        .o_res   (y_res)
    );

    als_mode_sel u_mode_sel (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_valid                 (y_valid),
        .i_side                  (y_side),
        .i_y                     (y_res[als_pkg::LUX_W-1:0]),
        .o_strobe                (o_strobe),
        .o_lux_q8                (o_lux_q8),
        .o_best_mode             (o_best_mode),
        .o_next_integration_code (o_next_integration_code),
        .o_next_gain_code        (o_next_gain_code),
        .o_settled               (o_settled),
        .o_saturated             (o_saturated),
        .o_bad_setting           (o_bad_setting)
    );

endmodule

/* bench/als_lux_autorange_unit_tb.sv */
// ----------------------------------------------------------------------------
// Lux unit testbench
// Sends raw light words with their time and gain codes, predicts the corrected
// lux, the best range and its codes for every word taken, and checks each
// strobed result against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module als_lux_autorange_unit_tb;

    import als_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_WORDS = 1600;
    localparam int SHOWN_ERRORS = 10;

    localparam logic [63:0] PRODUCT_CAP = 64'd1 << 62;
    localparam logic [63:0] LUX_CEILING = (64'd1 << LUX_W) - 64'd1;
    localparam int          XQ_SHIFT    = 16;
    localparam int          Y_SHIFT     = COEF_FRAC_BITS_DEF - 8 + XQ_SHIFT - LUX_FRAC_BITS;

    localparam logic [15:0] LUX_LIMITS [NUM_LIMITS] = '{
        16'd230, 16'd460, 16'd1840, 16'd3680, 16'd7360, 16'd14720, 16'd29440, 16'd58880
    };
    localparam logic [CODE_W-1:0] RANGE_TIME [NUM_MODES] = '{
        TIME_800MS, TIME_800MS, TIME_800MS, TIME_800MS, TIME_400MS,
        TIME_200MS, TIME_100MS, TIME_50MS, TIME_25MS
    };
    localparam logic [GAIN_W-1:0] RANGE_GAIN [NUM_MODES] = '{
        GAIN_X2, GAIN_X1, GAIN_X1_4, GAIN_X1_8, GAIN_X1_8,
        GAIN_X1_8, GAIN_X1_8, GAIN_X1_8, GAIN_X1_8
    };
    localparam logic [CODE_W-1:0] VALID_TIMES [6] = '{
        TIME_100MS, TIME_200MS, TIME_400MS, TIME_800MS, TIME_50MS, TIME_25MS
    };

    typedef struct packed {
        logic [LUX_W-1:0]  lux;
        logic [MODE_W-1:0] mode;
        logic [CODE_W-1:0] next_ic;
        logic [GAIN_W-1:0] next_gc;
        logic              settled;
        logic              saturated;
        logic              bad;
    } lux_report_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [RAW_W-1:0]    i_raw_count = '0;
    logic [CODE_W-1:0]   i_integration_code = '0;
    logic [GAIN_W-1:0]   i_gain_code = '0;
    logic                o_strobe;
    logic [LUX_W-1:0]    o_lux_q8;
    logic [MODE_W-1:0]   o_best_mode;
    logic [CODE_W-1:0]   o_next_integration_code;
    logic [GAIN_W-1:0]   o_next_gain_code;
    logic                o_settled;
    logic                o_saturated;
    logic                o_bad_setting;

    lux_report_t lux_reports_q [$];
    lux_report_t observed_report;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          no_idle = 1'b0;

    als_lux_autorange_unit DUT (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .start                   (start),
        .busy                    (busy),
        .i_raw_count             (i_raw_count),
        .i_integration_code      (i_integration_code),
        .i_gain_code             (i_gain_code),
        .o_strobe                (o_strobe),
        .o_lux_q8                (o_lux_q8),
        .o_best_mode             (o_best_mode),
        .o_next_integration_code (o_next_integration_code),
        .o_next_gain_code        (o_next_gain_code),
        .o_settled               (o_settled),
        .o_saturated             (o_saturated),
        .o_bad_setting           (o_bad_setting)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Lux predictor
    // ------------------------------------------------------------------
    function automatic int time_shift_of(input logic [CODE_W-1:0] code);
        case (code)
            TIME_25MS:  return 0;
            TIME_50MS:  return 1;
            TIME_100MS: return 2;
            TIME_200MS: return 3;
            TIME_400MS: return 4;
            TIME_800MS: return 5;
            default:    return -1;
        endcase
    endfunction

    function automatic int gain_shift_of(input logic [GAIN_W-1:0] code);
        case (code)
            GAIN_X1_8: return 0;
            GAIN_X1_4: return 1;
            GAIN_X1:   return 3;
            default:   return 4;
        endcase
    endfunction

    // round half up of num * 2^f / den
    function automatic logic [63:0] round_coef(input logic [63:0] num,
                                               input logic [63:0] den, input int f);
        logic [127:0] n;
        logic [127:0] d;
        n = (128'(num) << (f + 1)) + 128'(den);
        d = 128'(den) << 1;
        n = n / d;
        return n[63:0];
    endfunction

    function automatic logic [63:0] scaled_product(input logic [63:0] a,
                                                   input logic [63:0] b, input int sh);
        logic [127:0] p;
        p = (128'(a) * 128'(b)) >> sh;
        if (p > 128'(PRODUCT_CAP)) return PRODUCT_CAP;
        return p[63:0];
    endfunction

    // truncate toward zero: scale the magnitude, then restore the sign
    function automatic longint signed_product(input longint a, input logic [63:0] b,
                                              input int sh);
        logic [63:0] m;
        if (a < 0) begin
            m = scaled_product(64'(-a), b, sh);
            return -longint'(m);
        end
        return longint'(scaled_product(64'(a), b, sh));
    endfunction

    function automatic lux_report_t predict_lux(input logic [RAW_W-1:0] raw,
                                                input logic [CODE_W-1:0] ic,
                                                input logic [GAIN_W-1:0] gc);
        lux_report_t r;
        int          tsh;
        int          k;
        int          mode;
        logic        bad;
        logic        full;
        logic [63:0] xq;
        logic [63:0] y;
        longint      k3, k2, k1, k0, t2, t1, t0;
        tsh  = time_shift_of(ic);
        bad  = (tsh < 0);
        full = (raw == 16'hFFFF);
        y    = 64'd0;
        mode = int'(MODE_COARSE);
        if (!bad) begin
            k  = tsh + gain_shift_of(gc);
            k3 = longint'(round_coef(64'd60135, 64'd100000000000000000, COEF_FRAC_BITS_DEF));
            k2 = -longint'(round_coef(64'd93924, 64'd10000000000000, COEF_FRAC_BITS_DEF));
            k1 = longint'(round_coef(64'd81488, 64'd1000000000, COEF_FRAC_BITS_DEF));
            k0 = longint'(round_coef(64'd10023, 64'd10000, COEF_FRAC_BITS_DEF - 8));
            xq = (64'(raw) * 64'd1152 * (64'd1 << (XQ_SHIFT - k))) / 64'd625;
            t2 = k2 + signed_product(k3, xq, XQ_SHIFT);
            t1 = k1 + signed_product(t2, xq, XQ_SHIFT);
            t0 = k0 + signed_product(t1, xq, XQ_SHIFT + 8);
            if (t0 > 0) y = scaled_product(64'(t0), xq, Y_SHIFT);
            // range pick uses the unclamped value; full scale forces the coarsest
            if (!full) begin
                mode = 0;
                while (mode < NUM_LIMITS && y > (64'(LUX_LIMITS[mode]) << LUX_FRAC_BITS))
                    mode++;
            end
        end
        r.lux       = (y > LUX_CEILING) ? LUX_CEILING[LUX_W-1:0] : y[LUX_W-1:0];
        r.mode      = MODE_W'(mode);
        r.next_ic   = RANGE_TIME[mode];
        r.next_gc   = RANGE_GAIN[mode];
        r.settled   = !bad && RANGE_TIME[mode] == ic && RANGE_GAIN[mode] == gc;
        r.saturated = full;
        r.bad       = bad;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Word driver and result checker
    // ------------------------------------------------------------------
    task automatic send_reading(input logic [RAW_W-1:0] raw, input logic [CODE_W-1:0] ic,
                                input logic [GAIN_W-1:0] gc);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_raw_count        = raw;
        i_integration_code = ic;
        i_gain_code        = gc;
        start              = 1'b1;
        do @(posedge i_clk); while (busy);
        lux_reports_q.push_back(predict_lux(raw, ic, gc));
    endtask

    task automatic report_mismatch(input string what, input lux_report_t want,
                                   input lux_report_t got);
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS) begin
            $display({"tb: mismatch (%0s) expected lux=%0d mode=%0d next=%0d/%0d",
                      " st=%0b sat=%0b bad=%0b"},
                     what, want.lux, want.mode, want.next_ic, want.next_gc,
                     want.settled, want.saturated, want.bad);
            $display({"tb:               got lux=%0d mode=%0d next=%0d/%0d",
                      " st=%0b sat=%0b bad=%0b"},
                     got.lux, got.mode, got.next_ic, got.next_gc,
                     got.settled, got.saturated, got.bad);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            observed_report = '{lux: o_lux_q8, mode: o_best_mode,
                                next_ic: o_next_integration_code,
                                next_gc: o_next_gain_code, settled: o_settled,
                                saturated: o_saturated, bad: o_bad_setting};
            if (lux_reports_q.size() == 0)
                report_mismatch("no word pending", '0, observed_report);
            else if (observed_report !== lux_reports_q[0])
                report_mismatch("field", lux_reports_q.pop_front(), observed_report);
            else
                void'(lux_reports_q.pop_front());
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // count FFFE at every time code, smallest counts and FFFE at the most sensitive
    // range, patterned counts at the shortest time
    task automatic test_range_extremes;
        foreach (VALID_TIMES[i]) send_reading(16'hFFFE, VALID_TIMES[i], GAIN_X1_8);
        send_reading(16'h0000, TIME_800MS, GAIN_X2);
        send_reading(16'h0001, TIME_800MS, GAIN_X2);
        send_reading(16'hFFFE, TIME_800MS, GAIN_X2);
        send_reading(16'h5555, TIME_25MS, GAIN_X1);
        send_reading(16'hAAAA, TIME_25MS, GAIN_X1_4);
    endtask

    task automatic test_full_scale;
        send_reading(16'hFFFF, TIME_25MS, GAIN_X1_8);
        send_reading(16'hFFFF, TIME_800MS, GAIN_X2);
        send_reading(16'hFFFF, TIME_100MS, GAIN_X1);
    endtask

    task automatic test_undefined_time;
        logic [RAW_W-1:0] raw;
        for (int c = 0; c < 16; c++) begin
            if (time_shift_of(CODE_W'(c)) < 0) begin
                raw = (c == 15) ? 16'hFFFF : RAW_W'($urandom);
                send_reading(raw, CODE_W'(c), GAIN_W'($urandom));
            end
        end
    endtask

    // log-spread counts so every range is hit; mostly valid codes, often a
    // range's own codes so that settled shows up
    task automatic test_random_readings;
        int               nbits;
        int               pick;
        int               mode;
        logic [RAW_W-1:0] raw;
        logic [CODE_W-1:0] ic;
        logic [GAIN_W-1:0] gc;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if ($urandom_range(0, 59) == 0) no_idle = ~no_idle;
            nbits = $urandom_range(1, RAW_W);
            raw   = RAW_W'($urandom) & RAW_W'((32'd1 << nbits) - 32'd1);
            if ($urandom_range(0, 31) == 0) raw = 16'hFFFF;
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
                mode = $urandom_range(0, NUM_MODES - 1);
                ic   = RANGE_TIME[mode];
                gc   = RANGE_GAIN[mode];
            end else if (pick < 17) begin
                ic = VALID_TIMES[$urandom_range(0, 5)];
                gc = GAIN_W'($urandom);
            end else begin
                ic = CODE_W'($urandom);
                gc = GAIN_W'($urandom);
            end
            send_reading(raw, ic, gc);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_range_extremes();
        test_full_scale();
        test_undefined_time();
        test_random_readings();

        @(negedge i_clk);
        start = 1'b0;
        while (lux_reports_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
